/* rtl/dual_core_round_robin_task_picker_defines.svh */
// Assertion macros used by the task picker sequencer.
`ifndef DUAL_CORE_ROUND_ROBIN_TASK_PICKER_DEFINES_SVH
`define DUAL_CORE_ROUND_ROBIN_TASK_PICKER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DCRR_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define DCRR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/dcrr_pkg.sv */
package dcrr_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SCHED  = 2'd1,
    OP_EXIT   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_CORE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_st_t;

  localparam logic [1:0] AFF_ANY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FETCH,
    S_DONE
  } seq_state_t;

  // Write command from the sequencer to the slot table.
  typedef struct packed {
    logic     st_we;
    slot_st_t st_val;
    logic     aff_we;
    logic [1:0] aff_val;
    logic     sp_we;
  } tbl_cmd_t;

  // Combinational read of the table at the current address.
  typedef struct packed {
    slot_st_t   st;
    logic [1:0] aff;
  } tbl_rd_t;

endpackage

/* rtl/dcrr_table.sv */
module dcrr_table
  import dcrr_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(TASK_SLOTS)-1:0] addr,
  input  tbl_cmd_t                      cmd,
  input  logic [31:0]                   sp_wdata,
  output tbl_rd_t                       rd,
  output logic [31:0]                   sp_rdata
);

  slot_st_t   slot_state    [TASK_SLOTS];
  logic [1:0] slot_affinity [TASK_SLOTS];
  logic [31:0] sp_mem       [TASK_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i] <= ST_UNUSED;
      end
    end else if (cmd.st_we) begin
      slot_state[addr] <= cmd.st_val;
    end
  end

  // Affinity is always written by create before the slot can be ready.
  always_ff @(posedge clk) begin
    if (cmd.aff_we) begin
      slot_affinity[addr] <= cmd.aff_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sp_we) begin
      sp_mem[addr] <= sp_wdata;
    end
    sp_rdata <= sp_mem[addr];
  end

  assign rd.st  = slot_state[addr];
  assign rd.aff = slot_affinity[addr];

endmodule

/* rtl/dcrr_seq.sv */
`include "dual_core_round_robin_task_picker_defines.svh"

module dcrr_seq
  import dcrr_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic                          core,
  input  logic                          any_core,
  input  logic [7:0]                    pin_core,
  input  logic [31:0]                   new_task_sp,
  input  logic [31:0]                   interrupted_sp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [3:0]                    slot,
  output logic [31:0]                   resume_sp,
  output logic                          switched,
  output logic [$clog2(TASK_SLOTS)-1:0] addr,
  output tbl_cmd_t                      cmd,
  output logic [31:0]                   sp_wdata,
  input  tbl_rd_t                       rd,
  input  logic [31:0]                   sp_rdata
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

  seq_state_t state, state_next;

  // Latched request word
  op_t         op_q;
  logic        core_q;
  logic        any_q;
  logic [7:0]  pin_q;
  logic [31:0] nsp_q;
  logic [31:0] csp_q;

  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] step, step_next;

  logic          cur_vld      [2];
  logic          cur_vld_next [2];
  logic [IW-1:0] cur_idx      [2];
  logic [IW-1:0] cur_idx_next [2];
  logic          cursor_vld, cursor_vld_next;
  logic [IW-1:0] cursor, cursor_next;

  status_t     status_q, status_next;
  logic [3:0]  slot_q, slot_next;
  logic [31:0] rsp_q, rsp_next;
  logic        sw_q, sw_next;

  logic          cur_v;
  logic [IW-1:0] cur_i;
  logic          bad_pin;
  logic          hit_create;
  logic          hit_sched;
  logic          last_step;
  logic [IW-1:0] start_idx;

  assign cur_v      = cur_vld[core_q];
  assign cur_i      = cur_idx[core_q];
  assign bad_pin    = !any_q && (pin_q > 8'd1);
  assign hit_create = (rd.st == ST_UNUSED);
  assign hit_sched  = (rd.st == ST_READY) &&
                      ((rd.aff == AFF_ANY) || (rd.aff == {1'b0, core_q}));
  assign last_step  = (step == LAST);
  // Round robin starts just after the last chosen slot.
  assign start_idx  = !cursor_vld ? '0 :
                      (cursor == LAST) ? '0 : cursor + IW'(1);
  assign sp_wdata   = (op_q == OP_CREATE) ? nsp_q : csp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_vld[0] <= 1'b0;
      cur_vld[1] <= 1'b0;
      cursor_vld <= 1'b0;
    end else begin
      state      <= state_next;
      cur_vld[0] <= cur_vld_next[0];
      cur_vld[1] <= cur_vld_next[1];
      cursor_vld <= cursor_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op_t'(op);
      core_q <= core;
      any_q  <= any_core;
      pin_q  <= pin_core;
      nsp_q  <= new_task_sp;
      csp_q  <= interrupted_sp;
    end
    idx        <= idx_next;
    step       <= step_next;
    cur_idx[0] <= cur_idx_next[0];
    cur_idx[1] <= cur_idx_next[1];
    cursor     <= cursor_next;
    status_q   <= status_next;
    slot_q     <= slot_next;
    rsp_q      <= rsp_next;
    sw_q       <= sw_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (op_q)
          OP_CREATE: state_next = bad_pin ? S_DONE : S_SCAN;
          OP_SCHED:  state_next = S_SCAN;
          default:   state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (op_q == OP_CREATE) begin
          if (hit_create || last_step) state_next = S_DONE;
        end else begin
          if (hit_sched) state_next = S_FETCH;
          else if (last_step) state_next = S_DONE;
        end
      end
      S_FETCH: state_next = S_DONE;
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == S_IDLE);
    out_valid       = (state == S_DONE);
    addr            = idx;
    cmd             = '0;
    cmd.st_val      = ST_UNUSED;
    idx_next        = idx;
    step_next       = step;
    cur_vld_next[0] = cur_vld[0];
    cur_vld_next[1] = cur_vld[1];
    cur_idx_next[0] = cur_idx[0];
    cur_idx_next[1] = cur_idx[1];
    cursor_vld_next = cursor_vld;
    cursor_next     = cursor;
    status_next     = status_q;
    slot_next       = slot_q;
    rsp_next        = rsp_q;
    sw_next         = sw_q;

    unique case (state)
      S_DECODE: begin
        addr        = cur_i;
        step_next   = '0;
        idx_next    = (op_q == OP_CREATE) ? '0 : start_idx;
        status_next = STAT_OK;
        slot_next   = '0;
        rsp_next    = '0;
        sw_next     = 1'b0;
        unique case (op_q)
          OP_CREATE: begin
            if (bad_pin) status_next = STAT_BAD_CORE;
          end
          OP_SCHED: begin
            // Save the interrupted context and put its task back in the ring.
            if (cur_v && (rd.st == ST_RUNNING)) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_READY;
              cmd.sp_we  = 1'b1;
            end
          end
          OP_EXIT: begin
            if (cur_v) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_UNUSED;
              slot_next  = 4'(cur_i);
            end
            cur_vld_next[core_q] = 1'b0;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        step_next = step + IW'(1);
        idx_next  = (idx == LAST) ? '0 : idx + IW'(1);
        if (op_q == OP_CREATE) begin
          if (hit_create) begin
            cmd.st_we   = 1'b1;
            cmd.st_val  = ST_READY;
            cmd.aff_we  = 1'b1;
            cmd.aff_val = any_q ? AFF_ANY : {1'b0, pin_q[0]};
            cmd.sp_we   = 1'b1;
            slot_next   = 4'(idx);
          end else if (last_step) begin
            status_next = STAT_FULL;
          end
        end else begin
          if (hit_sched) begin
            cmd.st_we            = 1'b1;
            cmd.st_val           = ST_RUNNING;
            cur_vld_next[core_q] = 1'b1;
            cur_idx_next[core_q] = idx;
            cursor_vld_next      = 1'b1;
            cursor_next          = idx;
            slot_next            = 4'(idx);
            sw_next              = 1'b1;
          end else if (last_step) begin
            rsp_next = csp_q;
          end
        end
      end
      S_FETCH: begin
        // Saved pointer of the chosen slot, read on the scan hit.
        rsp_next = sp_rdata;
      end
      default: ;
    endcase
  end

  assign status    = status_q;
  assign slot      = slot_q;
  assign resume_sp = rsp_q;
  assign switched  = sw_q;

  `DCRR_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "ready while a result is pending")
  `DCRR_ASSERT_NOW(a_fetch_from_sched, state == S_FETCH,
                   op_q == OP_SCHED && $past(state) == S_SCAN, "fetch outside a schedule hit")
  `DCRR_ASSERT_NOW(a_sw_ok, out_valid && switched,
                   status == STAT_OK && op_q == OP_SCHED, "switch reported with error")
  `DCRR_ASSERT_NOW(a_sp_write_src, cmd.sp_we,
                   (state == S_DECODE && op_q == OP_SCHED) ||
                   (state == S_SCAN && op_q == OP_CREATE), "stray stack pointer write")
  `DCRR_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state == S_DECODE,
                    "accepted word not decoded")

endmodule

/* rtl/dual_core_round_robin_task_picker.sv */
// Two-core round robin task picker. One request word is taken when idle and
// its result is held on the output until taken; in_ready stays low meanwhile.
// A single slot-table port is walked by a small sequencer, one slot per clock:
// create searches from slot 0 for the lowest free slot, schedule scans round
// robin from just after the last chosen slot for a ready task the core may
// run. Exit, an unknown op or a bad pin core go from decode straight to the
// result; create scans until it finds a free slot or has examined every slot;
// schedule scans until a hit and then fetches the saved pointer of the chosen
// slot, or returns the interrupted pointer when nothing is eligible. The scan
// length thus sets how soon the block is free again: no new request is taken
// until the result of the last one has been taken.
// No clearing pass is needed after reset.
module dual_core_round_robin_task_picker
  import dcrr_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic        core,
  input  logic        any_core,
  input  logic [7:0]  pin_core,
  input  logic [31:0] new_task_sp,
  input  logic [31:0] interrupted_sp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [31:0] resume_sp,
  output logic        switched
);

  logic [$clog2(TASK_SLOTS)-1:0] addr;
  tbl_cmd_t    cmd;
  tbl_rd_t     rd;
  logic [31:0] sp_wdata;
  logic [31:0] sp_rdata;

  dcrr_seq #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .core          (core),
    .any_core      (any_core),
    .pin_core      (pin_core),
    .new_task_sp   (new_task_sp),
    .interrupted_sp(interrupted_sp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot          (slot),
    .resume_sp     (resume_sp),
    .switched      (switched),
    .addr          (addr),
    .cmd           (cmd),
    .sp_wdata      (sp_wdata),
    .rd            (rd),
    .sp_rdata      (sp_rdata)
  );

  dcrr_table #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .addr    (addr),
    .cmd     (cmd),
    .sp_wdata(sp_wdata),
    .rd      (rd),
    .sp_rdata(sp_rdata)
  );

endmodule
